[rtl/sptt_pkg.sv]
// ----------------------------------------------------------------------------
// sptt_pkg
// Shared types and constants for the sparse triplet transpose block.
// ----------------------------------------------------------------------------
package sptt_pkg;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_INDEX_BITS  = 10;
  localparam int CFG_W           = 11;
  localparam int VALUE_W         = 32;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_W-1:0] NUM_ROWS_RST = 11'd1024;
  localparam logic [CFG_W-1:0] NUM_COLS_RST = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_FINISH
  } sptt_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic rd_en;
  } sptt_store_ctl_t;

endpackage

[rtl/sptt_entry_store.sv]
// ----------------------------------------------------------------------------
// sptt_entry_store
// Triplet store: one write port filled in load order, one registered read
// port, fill count and overflow flag.
// ----------------------------------------------------------------------------
module sptt_entry_store #(
  parameter int MAX_ENTRIES = sptt_pkg::DEF_MAX_ENTRIES,
  parameter int INDEX_BITS  = sptt_pkg::DEF_INDEX_BITS,
  parameter int AW          = $clog2(MAX_ENTRIES),
  parameter int CNTW        = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sptt_pkg::sptt_store_ctl_t       ctl,
  input  logic [INDEX_BITS-1:0]           wr_row,
  input  logic [INDEX_BITS-1:0]           wr_col,
  input  logic [sptt_pkg::VALUE_W-1:0]    wr_value,
  input  logic [AW-1:0]                   rd_addr,
  output logic [INDEX_BITS-1:0]           rd_row,
  output logic [INDEX_BITS-1:0]           rd_col,
  output logic [sptt_pkg::VALUE_W-1:0]    rd_value,
  output logic [CNTW-1:0]                 count,
  output logic                            overflow
);
  import sptt_pkg::*;

  localparam int WORD_W = 2 * INDEX_BITS + VALUE_W;

  logic [WORD_W-1:0] mem [MAX_ENTRIES];
  logic [WORD_W-1:0] rd_data_r;
  logic [CNTW-1:0]   count_r;
  logic              overflow_r;
  logic              has_room;

  assign has_room = (count_r < CNTW'(MAX_ENTRIES));

  always_ff @(posedge clk) begin
    if (ctl.load && has_room) begin
      mem[count_r[AW-1:0]] <= {wr_row, wr_col, wr_value};
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else if (ctl.clear) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else if (ctl.load) begin
      if (has_room) begin
        count_r <= count_r + CNTW'(1);
      end else begin
        overflow_r <= 1'b1;
      end
    end
  end

  assign rd_row   = rd_data_r[WORD_W-1 -: INDEX_BITS];
  assign rd_col   = rd_data_r[VALUE_W +: INDEX_BITS];
  assign rd_value = rd_data_r[VALUE_W-1:0];
  assign count    = count_r;
  assign overflow = overflow_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(MAX_ENTRIES))
    else $error("store count beyond capacity");

  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load && !ctl.clear && !has_room |=> overflow_r)
    else $error("dropped load did not set overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> count_r == '0 && !overflow_r)
    else $error("clear did not empty the store");

endmodule

[rtl/sparse_triplet_transpose.sv]
// ----------------------------------------------------------------------------
// sparse_triplet_transpose
// Loads (row, col, value) triplets into a store and, on a run command, emits
// them column by column with row and column swapped.
//
//   channel  handshake          payload
//   in       start / busy       in_command, in_entry_row, in_entry_col,
//                               in_entry_value
//   out      out_valid strobe   out_row, out_col, out_value, out_is_entry,
//                               out_last, out_rows, out_cols,
//                               out_total_entries, out_overflowed
//   cfg      cfg_we             cfg_index, cfg_wdata
//
// A load leaves busy low, so loads may follow every cycle.
// A run reads one stored entry per cycle over every (column, entry) pair,
// through the scan, flush and finish states, or straight to finish when nothing
// is scanned; the final result strobes in the first cycle with busy low.
// The single memory read port sets the scan rate.
// Reset is synchronous; the store needs no clearing pass, only its count and overflow flag.
// Results are one-cycle strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
module sparse_triplet_transpose #(
  parameter int MAX_ENTRIES = sptt_pkg::DEF_MAX_ENTRIES,
  parameter int INDEX_BITS  = sptt_pkg::DEF_INDEX_BITS,
  parameter int AW          = $clog2(MAX_ENTRIES),
  parameter int CNTW        = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_command,
  input  logic [INDEX_BITS-1:0]              in_entry_row,
  input  logic [INDEX_BITS-1:0]              in_entry_col,
  input  logic signed [sptt_pkg::VALUE_W-1:0] in_entry_value,
  input  logic                               cfg_we,
  input  logic [sptt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sptt_pkg::CFG_W-1:0]         cfg_wdata,
  output logic                               out_valid,
  output logic [INDEX_BITS-1:0]              out_row,
  output logic [INDEX_BITS-1:0]              out_col,
  output logic signed [sptt_pkg::VALUE_W-1:0] out_value,
  output logic                               out_is_entry,
  output logic                               out_last,
  output logic [sptt_pkg::CFG_W-1:0]         out_rows,
  output logic [sptt_pkg::CFG_W-1:0]         out_cols,
  output logic [CNTW-1:0]                    out_total_entries,
  output logic                               out_overflowed
);
  import sptt_pkg::*;

  localparam int LW = (CFG_W > INDEX_BITS) ? CFG_W : INDEX_BITS;
  localparam logic [LW-1:0] COL_CAP = LW'((64'd1 << INDEX_BITS) - 64'd1);

  sptt_state_t state_r, state_nxt;

  logic [CFG_W-1:0]      num_rows_r;
  logic [CFG_W-1:0]      num_cols_r;
  logic [INDEX_BITS-1:0] col_r, col_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic                  rd_vld_r;
  logic [INDEX_BITS-1:0] rd_tag_r;
  logic                  pend_vld_r;
  logic [INDEX_BITS-1:0] pend_row_r;
  logic [INDEX_BITS-1:0] pend_col_r;
  logic [VALUE_W-1:0]    pend_val_r;

  logic                  out_valid_r;
  logic [INDEX_BITS-1:0] out_row_r;
  logic [INDEX_BITS-1:0] out_col_r;
  logic [VALUE_W-1:0]    out_val_r;
  logic                  out_is_entry_r;
  logic                  out_last_r;
  logic [CFG_W-1:0]      out_rows_r;
  logic [CFG_W-1:0]      out_cols_r;
  logic [CNTW-1:0]       out_total_r;
  logic                  out_ovf_r;

  sptt_store_ctl_t       store_ctl;
  logic [INDEX_BITS-1:0] rd_row;
  logic [INDEX_BITS-1:0] rd_col;
  logic [VALUE_W-1:0]    rd_value;
  logic [CNTW-1:0]       count;
  logic                  overflow;

  logic                  accept;
  logic                  run_go;
  logic                  nothing_to_scan;
  logic [LW-1:0]         ncols_m1;
  logic [INDEX_BITS-1:0] last_col;
  logic [CNTW-1:0]       count_m1;
  logic [AW-1:0]         last_idx;
  logic                  issue;
  logic                  finish;
  logic                  match;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign run_go = accept && (in_command == CMD_RUN);

  assign ncols_m1        = LW'(num_cols_r) - LW'(1);
  assign last_col        = (ncols_m1 > COL_CAP) ? COL_CAP[INDEX_BITS-1:0]
                                                : ncols_m1[INDEX_BITS-1:0];
  assign count_m1        = count - CNTW'(1);
  assign last_idx        = count_m1[AW-1:0];
  assign nothing_to_scan = (count == '0) || (num_cols_r == '0);
  assign match           = rd_vld_r && (rd_col == rd_tag_r);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= NUM_ROWS_RST;
      num_cols_r <= NUM_COLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_ROWS: num_rows_r <= cfg_wdata;
        CFG_NUM_COLS: num_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (run_go) begin
          state_nxt = nothing_to_scan ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((idx_r == last_idx) && (col_r == last_col)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    issue   = 1'b0;
    finish  = 1'b0;
    col_nxt = col_r;
    idx_nxt = idx_r;
    case (state_r)
      ST_SCAN: begin
        issue = 1'b1;
        if (idx_r == last_idx) begin
          idx_nxt = '0;
          if (col_r != last_col) begin
            col_nxt = col_r + INDEX_BITS'(1);
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_FINISH: begin
        finish  = 1'b1;
        col_nxt = '0;
        idx_nxt = '0;
      end
      default: ;
    endcase
    store_ctl.load  = accept && (in_command == CMD_LOAD);
    store_ctl.clear = finish;
    store_ctl.rd_en = issue;
  end

  sptt_entry_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .INDEX_BITS  (INDEX_BITS),
    .AW          (AW),
    .CNTW        (CNTW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (store_ctl),
    .wr_row   (in_entry_row),
    .wr_col   (in_entry_col),
    .wr_value (in_entry_value),
    .rd_addr  (idx_r),
    .rd_row   (rd_row),
    .rd_col   (rd_col),
    .rd_value (rd_value),
    .count    (count),
    .overflow (overflow)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      col_r      <= '0;
      idx_r      <= '0;
      rd_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= issue;
      if (finish) begin
        pend_vld_r <= 1'b0;
      end else if (match) begin
        pend_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_tag_r <= col_r;
    end
    if (match) begin
      pend_row_r <= rd_col;
      pend_col_r <= rd_row;
      pend_val_r <= rd_value;
    end
  end

  // result register: a held match goes out at the next match or at finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (match && pend_vld_r) || finish;
    end
  end

  always_ff @(posedge clk) begin
    if ((match && pend_vld_r) || finish) begin
      out_is_entry_r <= pend_vld_r;
      out_last_r     <= finish;
      out_rows_r     <= num_cols_r;
      out_cols_r     <= num_rows_r;
      out_total_r    <= count;
      out_ovf_r      <= overflow;
      if (pend_vld_r) begin
        out_row_r <= pend_row_r;
        out_col_r <= pend_col_r;
        out_val_r <= pend_val_r;
      end else begin
        out_row_r <= '0;
        out_col_r <= '0;
        out_val_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_value         = out_val_r;
  assign out_is_entry      = out_is_entry_r;
  assign out_last          = out_last_r;
  assign out_rows          = out_rows_r;
  assign out_cols          = out_cols_r;
  assign out_total_entries = out_total_r;
  assign out_overflowed    = out_ovf_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |=> out_valid_r && out_last_r)
    else $error("run ended without a final result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> state_r == ST_IDLE)
    else $error("final result while still busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_is_entry_r |-> out_last_r)
    else $error("end marker not flagged last");

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> count != '0)
    else $error("scan over an empty store");

endmodule

[tb/tb_sparse_triplet_transpose.sv]
// ----------------------------------------------------------------------------
// tb_sparse_triplet_transpose
// Self-checking bench for the sparse triplet transpose block. Loads triplets
// and run commands through the start/busy port, and changes the matrix size
// registers only while the block is idle. A scoreboard keeps its own copy of
// the entry store and predicts every transposed entry or end marker of each
// run. Each result strobe is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_sparse_triplet_transpose;
  timeunit 1ns;
  timeprecision 1ps;

  import sptt_pkg::*;

  localparam int MAXN        = DEF_MAX_ENTRIES;
  localparam int IXW         = DEF_INDEX_BITS;
  localparam int CNTW        = $clog2(MAXN + 1);
  localparam int ITEM_TARGET = 330;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct {
    logic [IXW-1:0]     row;
    logic [IXW-1:0]     col;
    logic [VALUE_W-1:0] value;
    logic               is_entry;
    logic               last;
    logic [CFG_W-1:0]   rows;
    logic [CFG_W-1:0]   cols;
    logic [CNTW-1:0]    total;
    logic               ovf;
  } xpose_result_t;

  class transpose_scoreboard;
    logic [IXW-1:0]     ent_row [MAXN];
    logic [IXW-1:0]     ent_col [MAXN];
    logic [VALUE_W-1:0] ent_val [MAXN];
    int                 stored;
    bit                 dropped;
    logic [CFG_W-1:0]   rows_reg;
    logic [CFG_W-1:0]   cols_reg;
    xpose_result_t      expected_q[$];
    int                 errors;

    function new();
      stored   = 0;
      dropped  = 0;
      rows_reg = NUM_ROWS_RST;
      cols_reg = NUM_COLS_RST;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_NUM_ROWS) begin
        rows_reg = data;
      end else begin
        cols_reg = data;
      end
    endfunction

    function void note_transfer(logic cmd, logic [IXW-1:0] r, logic [IXW-1:0] c,
                                logic [VALUE_W-1:0] v);
      int            scan;
      int            hits;
      int            n;
      xpose_result_t res;
      if (cmd == CMD_LOAD) begin
        if (stored < MAXN) begin
          ent_row[stored] = r;
          ent_col[stored] = c;
          ent_val[stored] = v;
          stored++;
        end else begin
          dropped = 1;
        end
        return;
      end
      scan = (int'(cols_reg) > (1 << IXW)) ? (1 << IXW) : int'(cols_reg);
      hits = 0;
      for (int j = 0; j < stored; j++) begin
        if (int'(ent_col[j]) < scan) hits++;
      end
      res.rows  = cols_reg;
      res.cols  = rows_reg;
      res.total = CNTW'(stored);
      res.ovf   = dropped;
      if (hits == 0) begin
        res.row      = '0;
        res.col      = '0;
        res.value    = '0;
        res.is_entry = 1'b0;
        res.last     = 1'b1;
        expected_q.push_back(res);
      end else begin
        n = 0;
        for (int k = 0; k < scan; k++) begin
          for (int j = 0; j < stored; j++) begin
            if (int'(ent_col[j]) == k) begin
              res.row      = ent_col[j];
              res.col      = ent_row[j];
              res.value    = ent_val[j];
              res.is_entry = 1'b1;
              res.last     = (n == hits - 1);
              expected_q.push_back(res);
              n++;
            end
          end
        end
      end
      stored  = 0;
      dropped = 0;
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(xpose_result_t got);
      xpose_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual row %0h col %0h value %0h",
                 $time, got.row, got.col, got.value);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("out_row", 32'(want.row), 32'(got.row));
      compare("out_col", 32'(want.col), 32'(got.col));
      compare("out_value", want.value, got.value);
      compare("out_is_entry", 32'(want.is_entry), 32'(got.is_entry));
      compare("out_last", 32'(want.last), 32'(got.last));
      compare("out_rows", 32'(want.rows), 32'(got.rows));
      compare("out_cols", 32'(want.cols), 32'(got.cols));
      compare("out_total_entries", 32'(want.total), 32'(got.total));
      compare("out_overflowed", 32'(want.ovf), 32'(got.ovf));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_command;
  logic [IXW-1:0]       in_entry_row;
  logic [IXW-1:0]       in_entry_col;
  logic signed [VALUE_W-1:0] in_entry_value;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 out_valid;
  logic [IXW-1:0]       out_row;
  logic [IXW-1:0]       out_col;
  logic signed [VALUE_W-1:0] out_value;
  logic                 out_is_entry;
  logic                 out_last;
  logic [CFG_W-1:0]     out_rows;
  logic [CFG_W-1:0]     out_cols;
  logic [CNTW-1:0]      out_total_entries;
  logic                 out_overflowed;

  transpose_scoreboard sb;
  int                  sent = 0;
  int                  cycles = 0;

  sparse_triplet_transpose dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_entry_row      (in_entry_row),
    .in_entry_col      (in_entry_col),
    .in_entry_value    (in_entry_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_value         (out_value),
    .out_is_entry      (out_is_entry),
    .out_last          (out_last),
    .out_rows          (out_rows),
    .out_cols          (out_cols),
    .out_total_entries (out_total_entries),
    .out_overflowed    (out_overflowed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    xpose_result_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      got.row      = out_row;
      got.col      = out_col;
      got.value    = out_value;
      got.is_entry = out_is_entry;
      got.last     = out_last;
      got.rows     = out_rows;
      got.cols     = out_cols;
      got.total    = out_total_entries;
      got.ovf      = out_overflowed;
      sb.check_result(got);
    end
  end

  task automatic idle_for(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_item(input logic cmd, input logic [IXW-1:0] r,
                           input logic [IXW-1:0] c, input logic [VALUE_W-1:0] v);
    @(negedge clk);
    start          <= 1'b1;
    in_command     <= cmd;
    in_entry_row   <= r;
    in_entry_col   <= c;
    in_entry_value <= v;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_transfer(cmd, r, c, v);
    sent++;
    // keep a long burst with no random idle gaps in the middle of the random part
    if ((sent < 120 || sent >= 200) && $urandom_range(0, 99) < 34) begin
      idle_for($urandom_range(1, 2));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_q.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    drain();
    write_cfg(CFG_NUM_ROWS, rows);
    write_cfg(CFG_NUM_COLS, cols);
  endtask

  initial begin
    int                 group;
    int                 scan;
    int                 nloads;
    logic [CFG_W-1:0]   rows;
    logic [CFG_W-1:0]   cols;
    logic [IXW-1:0]     col;
    logic [VALUE_W-1:0] val;

    sb             = new();
    rst_n          = 1'b0;
    start          = 1'b0;
    in_command     = CMD_LOAD;
    in_entry_row   = '0;
    in_entry_col   = '0;
    in_entry_value = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_NUM_ROWS;
    cfg_wdata      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty store at reset size, then extremes at the widest size
    send_item(CMD_RUN, 10'd0, 10'd0, 32'h0);
    send_item(CMD_LOAD, 10'd0, 10'd1023, 32'h7FFF_FFFF);
    send_item(CMD_LOAD, 10'd1023, 10'd0, 32'h8000_0000);
    send_item(CMD_LOAD, 10'd5, 10'd1023, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, 10'd1023, 10'd1023, 32'h0);
    send_item(CMD_RUN, 10'd1023, 10'd1023, 32'hFFFF_FFFF);

    // narrow matrix, columns out of range, load order within a column
    set_dims(11'd1, 11'd3);
    send_item(CMD_LOAD, 10'd1, 10'd2, 32'hA5A5_A5A5);
    send_item(CMD_LOAD, 10'd2, 10'd5, 32'h1);
    send_item(CMD_LOAD, 10'd3, 10'd0, 32'h5A5A_5A5A);
    send_item(CMD_LOAD, 10'd4, 10'd2, 32'hFFFF_FFFE);
    send_item(CMD_LOAD, 10'd6, 10'd3, 32'h7);
    send_item(CMD_RUN, 10'd0, 10'd0, 32'h0);

    // zero columns: only the end marker
    set_dims(11'd1024, 11'd0);
    send_item(CMD_LOAD, 10'd7, 10'd0, 32'h1234_5678);
    send_item(CMD_LOAD, 10'd8, 10'd1, 32'h8765_4321);
    send_item(CMD_RUN, 10'd0, 10'd0, 32'h0);

    // every stored entry beyond the last column
    set_dims(11'd17, 11'd1);
    send_item(CMD_LOAD, 10'd9, 10'd1, 32'hDEAD_BEEF);
    send_item(CMD_LOAD, 10'd10, 10'd900, 32'h0BAD_F00D);
    send_item(CMD_RUN, 10'd0, 10'd0, 32'h0);

    group = 0;
    while (sent < ITEM_TARGET) begin
      if (group == 0 || $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 7))
          0:       rows = 11'd1;
          1:       rows = 11'd1024;
          default: rows = 11'($urandom_range(1, 1024));
        endcase
        case ($urandom_range(0, 15))
          0:       cols = 11'd1024;
          1:       cols = 11'd1;
          2:       cols = 11'd0;
          default: cols = 11'($urandom_range(2, 16));
        endcase
        if (group == 0) cols = 11'($urandom_range(1, 16));
        set_dims(rows, cols);
      end
      scan = (int'(sb.cols_reg) > 1024) ? 1024 : int'(sb.cols_reg);
      if (scan > 64) begin
        nloads = $urandom_range(0, 4);
      end else if (group == 0 || $urandom_range(0, 9) == 0) begin
        nloads = $urandom_range(MAXN - 2, MAXN + 6);
      end else begin
        nloads = $urandom_range(0, 12);
      end
      for (int i = 0; i < nloads; i++) begin
        if (scan > 0 && $urandom_range(0, 4) != 0) begin
          col = IXW'($urandom_range(0, scan - 1));
        end else begin
          col = IXW'($urandom_range(0, 1023));
        end
        case ($urandom_range(0, 9))
          0:       val = 32'h7FFF_FFFF;
          1:       val = 32'h8000_0000;
          default: val = $urandom;
        endcase
        send_item(CMD_LOAD, IXW'($urandom_range(0, 1023)), col, val);
      end
      send_item(CMD_RUN, IXW'($urandom_range(0, 1023)), IXW'($urandom_range(0, 1023)),
                $urandom);
      group++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
